// File: rtl/led_matrix_row_scan_assert.svh
// Assertion macros used by the checker file of the row scanner.
`ifndef LED_MATRIX_ROW_SCAN_ASSERT_SVH
`define LED_MATRIX_ROW_SCAN_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LMRS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("row scan assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LMRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("row scan assertion failed");

`endif

// File: rtl/lmrs_pkg.sv
package lmrs_pkg;

   localparam int ROW_COUNT = 8;
   localparam int COL_COUNT = 8;
   localparam int ROW_W     = $clog2(ROW_COUNT);
   localparam int COL_W     = $clog2(COL_COUNT);
   localparam int MASK_W    = ROW_COUNT * COL_COUNT;
   localparam int PAGE_W    = 8;
   localparam int CSR_IDX_W = 8;

   localparam logic [ROW_COUNT-1:0] ROW_SELECT_IDLE = '1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_LEDS_DISABLED = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASSIVE_MODE  = 8'd1;

   // What one row lane finds.
   typedef struct packed {
      logic [COL_COUNT-1:0] cols;
      logic                 lit;
      logic [COL_W-1:0]     pick;
   } lane_result_type;

   // What the merging stage decides for one word.
   typedef struct packed {
      logic                 drive;
      logic                 single;
      logic [ROW_COUNT-1:0] row_select_n;
      logic [COL_COUNT-1:0] column_bits;
      logic [ROW_W-1:0]     row_index;
      logic [COL_W-1:0]     pick_col;
   } merge_result_type;

endpackage

// File: rtl/lmrs_lane.sv
module lmrs_lane (
   input  logic [lmrs_pkg::COL_COUNT-1:0] row_bits,
   input  logic [lmrs_pkg::COL_W-1:0]     col_start,
   output lmrs_pkg::lane_result_type      result
);
   import lmrs_pkg::*;

   logic [COL_COUNT-1:0] cols;
   logic                 found;
   logic [COL_W-1:0]     pick;
   logic [COL_W-1:0]     idx;

   // Column i of a row sits at mask bit 7-i of that row's byte.
   always_comb begin
      for (int i = 0; i < COL_COUNT; i++) begin
         cols[i] = row_bits[COL_COUNT-1-i];
      end
   end

   // First lit column found by rotating upward from the start column.
   always_comb begin
      found = 1'b0;
      pick  = col_start;
      idx   = col_start;
      for (int k = 0; k < COL_COUNT; k++) begin
         idx = col_start + COL_W'(k);
         if (!found && cols[idx]) begin
            found = 1'b1;
            pick  = idx;
         end
      end
   end

   assign result.cols = cols;
   assign result.lit  = |cols;
   assign result.pick = pick;

endmodule

// File: rtl/lmrs_merge.sv
module lmrs_merge (
   input  lmrs_pkg::lane_result_type [lmrs_pkg::ROW_COUNT-1:0] lanes,
   input  logic [lmrs_pkg::ROW_W-1:0]                         row_start,
   output lmrs_pkg::merge_result_type                         result
);
   import lmrs_pkg::*;

   logic [ROW_COUNT-1:0] lit;
   logic                 found;
   logic [ROW_W-1:0]     row;
   logic [ROW_W-1:0]     idx;
   logic                 single;
   lane_result_type      chosen;

   always_comb begin
      for (int r = 0; r < ROW_COUNT; r++) begin
         lit[r] = lanes[r].lit;
      end
   end

   // Exactly one lit row means a single column is driven.
   assign single = (lit != '0) && ((lit & (lit - ROW_COUNT'(1))) == '0);

   // Skip dark rows, rotating upward from the start row.
   always_comb begin
      found = 1'b0;
      row   = row_start;
      idx   = row_start;
      for (int k = 0; k < ROW_COUNT; k++) begin
         idx = row_start + ROW_W'(k);
         if (!found && lit[idx]) begin
            found = 1'b1;
            row   = idx;
         end
      end
   end

   assign chosen = lanes[row];

   // Build the drive word from the chosen lane.
   always_comb begin
      result.drive        = found;
      result.single       = found && single;
      result.row_index    = found ? row : '0;
      result.pick_col     = chosen.pick;
      result.row_select_n = ROW_SELECT_IDLE;
      result.column_bits  = '0;
      if (found) begin
         result.row_select_n[ROW_W'(ROW_COUNT-1) - row] = 1'b0;
         if (single) begin
            result.column_bits[chosen.pick] = 1'b1;
         end else begin
            result.column_bits = chosen.cols;
         end
      end
   end

endmodule

// File: rtl/led_matrix_row_scan.sv
// A result word is registered in the output register once its request is in the work register
// and the output register is free or being read. The single work register holds a word until
// its merged result is registered, because the row and column pointers feed the next word, so
// no new word is taken before then. Eight row lanes and the merging stage settle a word combinationally.
// Reset (synchronous, active high) clears pointers, page memories, configuration and
// all valid flags.
module led_matrix_row_scan (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: led_lit_mask[63:0], refresh_page[71:64]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [71:0]                    req_tdata,
   // rsp_tdata: row_select_n[7:0], column_bits[15:8], row_index[18:16], zero pad[23:19]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,
   // rsp_tuser: drive_valid[0]
   output logic [0:0]                     rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lmrs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic                           csr_data
);
   import lmrs_pkg::*;

   logic                 leds_disabled_ff, leds_disabled_in;
   logic                 passive_mode_ff, passive_mode_in;
   logic                 work_valid_ff, work_valid_in;
   logic [MASK_W-1:0]    work_mask_ff, work_mask_in;
   logic [PAGE_W-1:0]    work_page_ff, work_page_in;
   logic [ROW_W-1:0]     row_pointer_ff, row_pointer_in;
   logic [COL_W-1:0]     column_pointer_ff, column_pointer_in;
   logic [PAGE_W-1:0]    last_row_page_ff, last_row_page_in;
   logic [PAGE_W-1:0]    last_column_page_ff, last_column_page_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [23:0]          rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_user_in;

   logic                 req_fire;
   logic                 advance;
   logic                 enabled;
   logic [ROW_W-1:0]     row_start;
   logic [COL_W-1:0]     col_start;
   lane_result_type [ROW_COUNT-1:0] lanes;
   merge_result_type     merged;

   assign csr_ready  = 1'b1;
   assign req_tready = !work_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign advance    = work_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign enabled    = !leds_disabled_ff && !passive_mode_ff;

   // A page change steps the row and column start points once.
   assign row_start = row_pointer_ff + ROW_W'(work_page_ff != last_row_page_ff);
   assign col_start = column_pointer_ff + COL_W'(work_page_ff != last_column_page_ff);

   // One lane per matrix row.
   for (genvar r = 0; r < ROW_COUNT; r++) begin : g_lane
      lmrs_lane u_lane (
         .row_bits  (work_mask_ff[(ROW_COUNT-1-r)*COL_COUNT +: COL_COUNT]),
         .col_start (col_start),
         .result    (lanes[r])
      );
   end

   lmrs_merge u_merge (
      .lanes     (lanes),
      .row_start (row_start),
      .result    (merged)
   );

   // Configuration writes.
   always_comb begin
      leds_disabled_in = leds_disabled_ff;
      passive_mode_in  = passive_mode_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LEDS_DISABLED: leds_disabled_in = csr_data;
            CSR_PASSIVE_MODE:  passive_mode_in  = csr_data;
            default: ;
         endcase
      end
   end

   // Work register takes a word and releases it into the output register.
   always_comb begin
      work_valid_in = work_valid_ff;
      work_mask_in  = work_mask_ff;
      work_page_in  = work_page_ff;
      if (req_fire) begin
         work_valid_in = 1'b1;
         work_mask_in  = req_tdata[MASK_W-1:0];
         work_page_in  = req_tdata[MASK_W +: PAGE_W];
      end else if (advance) begin
         work_valid_in = 1'b0;
      end
   end

   // Pointer and page state moves only when an enabled word completes.
   always_comb begin
      row_pointer_in      = row_pointer_ff;
      column_pointer_in   = column_pointer_ff;
      last_row_page_in    = last_row_page_ff;
      last_column_page_in = last_column_page_ff;
      if (advance && enabled) begin
         last_row_page_in = work_page_ff;
         row_pointer_in   = merged.drive ? merged.row_index : row_start;
         if (merged.single) begin
            last_column_page_in = work_page_ff;
            column_pointer_in   = merged.pick_col;
         end
      end
   end

   // Output register; suppressed words carry the idle pattern.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (enabled && merged.drive) begin
            rsp_user_in = 1'b1;
            rsp_data_in = {5'b0, merged.row_index, merged.column_bits, merged.row_select_n};
         end else begin
            rsp_user_in = 1'b0;
            rsp_data_in = {5'b0, ROW_W'(0), COL_COUNT'(0), ROW_SELECT_IDLE};
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leds_disabled_ff    <= 1'b0;
         passive_mode_ff     <= 1'b0;
         work_valid_ff       <= 1'b0;
         row_pointer_ff      <= '0;
         column_pointer_ff   <= '0;
         last_row_page_ff    <= '0;
         last_column_page_ff <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         leds_disabled_ff    <= leds_disabled_in;
         passive_mode_ff     <= passive_mode_in;
         work_valid_ff       <= work_valid_in;
         row_pointer_ff      <= row_pointer_in;
         column_pointer_ff   <= column_pointer_in;
         last_row_page_ff    <= last_row_page_in;
         last_column_page_ff <= last_column_page_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_mask_ff <= work_mask_in;
      work_page_ff <= work_page_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule

// File: rtl/lmrs_checker.sv
`include "led_matrix_row_scan_assert.svh"

module lmrs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);
   import lmrs_pkg::*;

   // A stalled result word holds its contents.
   `LMRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Only one word is in work at a time.
   `LMRS_ASSERT_NEXT(a_one_in_work, clock, reset, req_tvalid && req_tready, !req_tready)

   // An undriven word carries the idle pattern.
   `LMRS_ASSERT_NOW(a_idle_word, clock, reset, rsp_tvalid && !rsp_tuser[0], (rsp_tdata[23:8] == 16'h0000) && (rsp_tdata[7:0] == ROW_SELECT_IDLE))

   // A driven word selects exactly its own row and lights some column.
   `LMRS_ASSERT_NOW(a_drive_word, clock, reset, rsp_tvalid && rsp_tuser[0], (rsp_tdata[7:0] == ~(8'h01 << (3'd7 - rsp_tdata[18:16]))) && (rsp_tdata[15:8] != 8'h00) && (rsp_tdata[23:19] == 5'd0))

endmodule

bind led_matrix_row_scan lmrs_checker u_lmrs_checker (.*);
